>>> rtl/core/hsv_pkg.sv
// shared types and constants for the hsv to led drive converter
package hsv_pkg;

  localparam int FRAC_BITS_DEF = 12;

  // request and drive level field widths
  localparam int HUE_W = 16;
  localparam int SAT_W = 14;
  localparam int LVL_W = 16;

  // luminance, 1.0 = 65536
  localparam int             Y_W   = 17;
  localparam logic [Y_W-1:0] Y_ONE = 17'h10000;
  localparam int             Y_CUBE_SHIFT = 32;
  localparam int             DRIVE_SHIFT  = 16;

  // widest unit-range value (FRAC_BITS at its upper limit of 16)
  localparam int UNIT_MAX_W = 17;

  // hue
  localparam int HUE_FULL   = 5760;
  localparam int HUE_SECTOR = 960;
  localparam int HUE_CL_W   = 13;
  localparam int REM_W      = 10;
  // 960 = 64 * 15
  localparam int SEC_PRE    = 6;
  localparam int SEC_DIV    = 15;

  // linear lightness segment: 65536000 / 9023 = 7263 + 1951 / 9023
  localparam int LIN_INT = 7263;
  localparam int LIN_FRC = 1951;
  localparam int LIN_DIV = 9023;

  // cubic lightness segment: 65536 / 116 = 2^14 / 29
  localparam int CUB_SHIFT = 14;
  localparam int CUB_DIV   = 29;
  localparam int MCUB_W    = 21;
  localparam int CUB_K     = 26;
  localparam int CUB_M_W   = 22;
  localparam logic [CUB_M_W-1:0] CUB_M =
    CUB_M_W'(((64'd1 << CUB_K) + 64'(CUB_DIV - 1)) / 64'(CUB_DIV));

  // pipeline depth, stage 6 is the output register
  localparam int STG_N = 6;
  typedef logic [STG_N:1] stage_vec_t;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = '0;
  localparam logic [LVL_W-1:0]     MAX_LEVEL_RST = 16'd255;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_e;

  typedef struct packed {
    logic [Y_W-1:0]        y;
    logic [UNIT_MAX_W-1:0] inv_s;
    logic [UNIT_MAX_W-1:0] inv_f;
    logic [UNIT_MAX_W-1:0] inv_g;
    sector_e               sec;
  } front_t;

endpackage

>>> rtl/core/hsv_if.sv
// valid/ready channels for hsv requests and rgb drive results
interface hsv_in_if import hsv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [HUE_W-1:0] hue_deg16;
  logic signed [SAT_W-1:0] saturation;
  logic signed [SAT_W-1:0] brightness;

  modport source (output valid, hue_deg16, saturation, brightness, input ready);
  modport sink   (input valid, hue_deg16, saturation, brightness, output ready);
endinterface

interface hsv_out_if import hsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] red;
  logic [LVL_W-1:0] green;
  logic [LVL_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/core/hsv_to_led_pwm.sv
// top level: hsv color in, common-anode rgb drive levels out
//
// hsv_i takes one color request per cycle while hsv_i.ready is high (hue
// in 1/16 degree, saturation and value in signed fixed point); rgb_o
// returns one set of red, green and blue drive levels per request, in
// request order. both channels accept a transfer when valid and ready are
// high at a rising clock edge. the apb port holds max_level at byte
// address 0; pready is tied high and a write lands at the access-phase
// edge. write it only while idle. the datapath is six register stages,
// the last one being the output register, and with rgb_o.ready held
// high one request enters every cycle.
// each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up under a stall and hsv_i.ready
// only falls once stage 1 holds a request that cannot advance.
// reset empties the pipeline (no pending results, hsv_i.ready high) and
// sets max_level to 255.
module hsv_to_led_pwm import hsv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  hsv_in_if.sink                hsv_i,
  hsv_out_if.source             rgb_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  stage_vec_t       en;
  stage_vec_t       vld_q;
  logic [LVL_W-1:0] max_level;
  front_t           front;

  always_comb begin
    en[STG_N] = !vld_q[STG_N] || rgb_o.ready;
    for (int k = STG_N - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= hsv_i.valid;
      end
      for (int k = 2; k <= STG_N; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign hsv_i.ready = en[1];
  assign rgb_o.valid = vld_q[STG_N];

  hsv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_level_o (max_level)
  );

  hsv_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .hue_i   (hsv_i.hue_deg16),
    .sat_i   (hsv_i.saturation),
    .bri_i   (hsv_i.brightness),
    .front_o (front)
  );

  hsv_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk_i       (clk_i),
    .en_i        (en),
    .front_i     (front),
    .max_level_i (max_level),
    .red_o       (rgb_o.red),
    .green_o     (rgb_o.green),
    .blue_o      (rgb_o.blue)
  );

  // a blocked request input means stage 1 is occupied
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> vld_q[1])
    else $error("hsv_i.ready low with stage 1 empty");

  // a draining output never back-pressures the requester
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_o.ready |-> hsv_i.ready)
    else $error("hsv_i.ready low while rgb_o.ready high");

  a_lum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> front.y <= Y_ONE)
    else $error("luminance above full scale");

  a_sector_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> front.sec <= SEC_MAG_RED)
    else $error("hue sector out of range");

endmodule

>>> rtl/core/hsv_cfg.sv
// apb register block holding the full-scale drive level
module hsv_cfg import hsv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LVL_W-1:0]      max_level_o
);

  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 hit_max;
  logic [LVL_W-1:0]     max_level_q;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_MAX_LEVEL: hit_max = 1'b1;
      default:       hit_max = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MAX_LEVEL_RST;
    end else if (psel && penable && pwrite && pready && hit_max) begin
      max_level_q <= pwdata[LVL_W-1:0];
    end
  end

  assign prdata      = hit_max ? CFG_DATA_W'(max_level_q) : '0;
  assign max_level_o = max_level_q;

endmodule

>>> rtl/core/hsv_front.sv
// stages 1-4: clamping, lightness curve, hue sector and saturation fractions
module hsv_front import hsv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  stage_vec_t              en_i,
  input  logic signed [HUE_W-1:0] hue_i,
  input  logic signed [SAT_W-1:0] sat_i,
  input  logic signed [SAT_W-1:0] bri_i,
  output front_t                  front_o
);

  localparam int UW   = FRAC_BITS + 1;
  localparam int CL_W = 18;
  localparam logic [UW-1:0] ONE = UW'(1 << FRAC_BITS);

  localparam int PA_W = UW + 13;
  localparam int PB_W = UW + 11;
  localparam int LW   = UW + 5;
  localparam int AW   = UW + 7;
  localparam int XW   = UW + REM_W;

  localparam int LIN_K   = PB_W + 14;
  localparam int LIN_M_W = LIN_K - 13;
  localparam logic [LIN_M_W-1:0] LIN_M =
    LIN_M_W'(((64'd1 << LIN_K) + 64'(LIN_DIV - 1)) / 64'(LIN_DIV));

  localparam int SF_N   = XW - SEC_PRE;
  localparam int SF_K   = SF_N + 4;
  localparam int SF_M_W = SF_K - 3;
  localparam logic [SF_M_W-1:0] SF_M =
    SF_M_W'(((64'd1 << SF_K) + 64'(SEC_DIV - 1)) / 64'(SEC_DIV));
  localparam int SF_P_W = SF_N + SF_M_W;

  localparam int T2_W = 2 * Y_W;
  localparam int T3_W = 3 * Y_W;

  function automatic logic [UW-1:0] clamp_unit(input logic signed [SAT_W-1:0] x);
    logic signed [CL_W-1:0] xe;
    xe = CL_W'(x);
    if (xe < 0) begin
      return '0;
    end else if (xe > $signed(CL_W'(ONE))) begin
      return ONE;
    end
    return UW'(xe);
  endfunction

  // stage 1
  logic [UW-1:0]             s_d, v_d;
  logic [HUE_CL_W-1:0]       h_d, base_d;
  sector_e                   sec_d;
  logic [REM_W-1:0]          rem_d;
  logic                      lin_d;
  logic [AW-1:0]             a_d;
  logic [AW+CUB_SHIFT-1:0]   ash_d;

  logic [UW-1:0]             s1_s_q;
  sector_e                   s1_sec_q;
  logic [REM_W-1:0]          s1_rem_q;
  logic                      s1_lin_q;
  logic [PA_W-1:0]           s1_pa_q;
  logic [PB_W-1:0]           s1_pb_q;
  logic [MCUB_W-1:0]         s1_mcub_q;

  assign s_d = clamp_unit(sat_i);
  assign v_d = clamp_unit(bri_i);
  // negative hue and full circle both land on zero
  assign h_d = (hue_i < 0 || hue_i >= $signed(HUE_W'(HUE_FULL))) ? '0 : HUE_CL_W'(hue_i);

  always_comb begin
    if (h_d >= HUE_CL_W'(5 * HUE_SECTOR)) begin
      sec_d  = SEC_MAG_RED;
      base_d = HUE_CL_W'(5 * HUE_SECTOR);
    end else if (h_d >= HUE_CL_W'(4 * HUE_SECTOR)) begin
      sec_d  = SEC_BLU_MAG;
      base_d = HUE_CL_W'(4 * HUE_SECTOR);
    end else if (h_d >= HUE_CL_W'(3 * HUE_SECTOR)) begin
      sec_d  = SEC_CYN_BLU;
      base_d = HUE_CL_W'(3 * HUE_SECTOR);
    end else if (h_d >= HUE_CL_W'(2 * HUE_SECTOR)) begin
      sec_d  = SEC_GRN_CYN;
      base_d = HUE_CL_W'(2 * HUE_SECTOR);
    end else if (h_d >= HUE_CL_W'(HUE_SECTOR)) begin
      sec_d  = SEC_YEL_GRN;
      base_d = HUE_CL_W'(HUE_SECTOR);
    end else begin
      sec_d  = SEC_RED_YEL;
      base_d = '0;
    end
  end

  assign rem_d = REM_W'(h_d - base_d);
  // linear segment at or below 8 percent: v * 100 <= 8 * one
  assign lin_d = (LW'(v_d) * LW'(25)) <= (LW'(ONE) << 1);
  assign a_d   = AW'(v_d) * AW'(100) + (AW'(ONE) << 4);
  assign ash_d = (AW + CUB_SHIFT)'(a_d) << CUB_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_s_q    <= s_d;
      s1_sec_q  <= sec_d;
      s1_rem_q  <= rem_d;
      s1_lin_q  <= lin_d;
      s1_pa_q   <= PA_W'(v_d) * PA_W'(LIN_INT);
      s1_pb_q   <= PB_W'(v_d) * PB_W'(LIN_FRC);
      s1_mcub_q <= MCUB_W'(ash_d >> FRAC_BITS);
    end
  end

  // stage 2: saturation times hue remainder, reciprocal divides of the curve
  logic [PB_W+LIN_M_W-1:0]   qb_prod;
  logic [MCUB_W+CUB_M_W-1:0] tc_prod;

  logic [UW-1:0]             s2_s_q;
  sector_e                   s2_sec_q;
  logic                      s2_lin_q;
  logic [PA_W-1:0]           s2_pa_q;
  logic [UW-1:0]             s2_qb_q;
  logic [Y_W-1:0]            s2_tc_q;
  logic [XW-1:0]             s2_xf_q, s2_xg_q;

  assign qb_prod = (PB_W + LIN_M_W)'(s1_pb_q) * (PB_W + LIN_M_W)'(LIN_M);
  assign tc_prod = (MCUB_W + CUB_M_W)'(s1_mcub_q) * (MCUB_W + CUB_M_W)'(CUB_M);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s2_s_q   <= s1_s_q;
      s2_sec_q <= s1_sec_q;
      s2_lin_q <= s1_lin_q;
      s2_pa_q  <= s1_pa_q;
      s2_qb_q  <= UW'(qb_prod >> LIN_K);
      s2_tc_q  <= Y_W'(tc_prod >> CUB_K);
      s2_xf_q  <= XW'(s1_s_q) * XW'(s1_rem_q);
      s2_xg_q  <= XW'(s1_s_q) * XW'(REM_W'(HUE_SECTOR) - s1_rem_q);
    end
  end

  // stage 3: divide by 960 as shift then divide by 15, linear result, t squared
  logic [SF_P_W-1:0] pf_prod, pg_prod;
  logic [PA_W-1:0]   ylin_sum;

  logic [UW-1:0]     s3_s_q, s3_sf_q, s3_sg_q;
  sector_e           s3_sec_q;
  logic              s3_lin_q;
  logic [Y_W-1:0]    s3_ylin_q, s3_tc_q;
  logic [T2_W-1:0]   s3_t2_q;

  assign pf_prod  = SF_P_W'(s2_xf_q >> SEC_PRE) * SF_P_W'(SF_M);
  assign pg_prod  = SF_P_W'(s2_xg_q >> SEC_PRE) * SF_P_W'(SF_M);
  assign ylin_sum = s2_pa_q + PA_W'(s2_qb_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s3_s_q    <= s2_s_q;
      s3_sec_q  <= s2_sec_q;
      s3_lin_q  <= s2_lin_q;
      s3_sf_q   <= UW'(pf_prod >> SF_K);
      s3_sg_q   <= UW'(pg_prod >> SF_K);
      s3_ylin_q <= Y_W'(ylin_sum >> FRAC_BITS);
      s3_tc_q   <= s2_tc_q;
      s3_t2_q   <= T2_W'(s2_tc_q) * T2_W'(s2_tc_q);
    end
  end

  // stage 4: luminance and inverted fractions
  logic [T3_W-1:0] t3_prod;
  front_t          front_d, front_q;

  assign t3_prod = T3_W'(s3_t2_q) * T3_W'(s3_tc_q);

  always_comb begin
    front_d.y     = s3_lin_q ? s3_ylin_q : Y_W'(t3_prod >> Y_CUBE_SHIFT);
    front_d.inv_s = UNIT_MAX_W'(ONE - s3_s_q);
    front_d.inv_f = UNIT_MAX_W'(ONE - s3_sf_q);
    front_d.inv_g = UNIT_MAX_W'(ONE - s3_sg_q);
    front_d.sec   = s3_sec_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

>>> rtl/core/hsv_mix.sv
// stages 5-6: sector products, channel select and inverted drive scaling
module hsv_mix import hsv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  stage_vec_t       en_i,
  input  front_t           front_i,
  input  logic [LVL_W-1:0] max_level_i,
  output logic [LVL_W-1:0] red_o,
  output logic [LVL_W-1:0] green_o,
  output logic [LVL_W-1:0] blue_o
);

  localparam int PW = 2 * Y_W;
  localparam int DW = Y_W + LVL_W;

  function automatic logic [Y_W-1:0] shade(input logic [Y_W-1:0] y,
                                           input logic [UNIT_MAX_W-1:0] f);
    logic [PW-1:0] prod;
    prod = PW'(y) * PW'(f);
    return Y_W'(prod >> FRAC_BITS);
  endfunction

  function automatic logic [LVL_W-1:0] drive(input logic [Y_W-1:0] x,
                                             input logic [LVL_W-1:0] lvl);
    logic [DW-1:0] prod;
    prod = DW'(Y_ONE - x) * DW'(lvl);
    return LVL_W'(prod >> DRIVE_SHIFT);
  endfunction

  // stage 5
  logic [Y_W-1:0] y_q, p_q, q_q, t_q;
  sector_e        sec_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      y_q   <= front_i.y;
      p_q   <= shade(front_i.y, front_i.inv_s);
      q_q   <= shade(front_i.y, front_i.inv_f);
      t_q   <= shade(front_i.y, front_i.inv_g);
      sec_q <= front_i.sec;
    end
  end

  // stage 6
  logic [Y_W-1:0]   r_sel, g_sel, b_sel;
  logic [LVL_W-1:0] red_q, green_q, blue_q;

  always_comb begin
    case (sec_q)
      SEC_RED_YEL: begin r_sel = y_q; g_sel = t_q; b_sel = p_q; end
      SEC_YEL_GRN: begin r_sel = q_q; g_sel = y_q; b_sel = p_q; end
      SEC_GRN_CYN: begin r_sel = p_q; g_sel = y_q; b_sel = t_q; end
      SEC_CYN_BLU: begin r_sel = p_q; g_sel = q_q; b_sel = y_q; end
      SEC_BLU_MAG: begin r_sel = t_q; g_sel = p_q; b_sel = y_q; end
      SEC_MAG_RED: begin r_sel = y_q; g_sel = p_q; b_sel = q_q; end
      default:     begin r_sel = y_q; g_sel = p_q; b_sel = q_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      red_q   <= drive(r_sel, max_level_i);
      green_q <= drive(g_sel, max_level_i);
      blue_q  <= drive(b_sel, max_level_i);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

>>> bench/hsv_drive_check.sv
// scoreboard that predicts the rgb drive levels of each hsv request and checks them
`timescale 1ns / 100ps
module hsv_drive_check import hsv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  hsv_in_if                     hsv_i,
  hsv_out_if                    rgb_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  localparam int                FRAC = FRAC_BITS_DEF;
  localparam longint unsigned   ONE  = 64'd1 << FRAC;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } drive_set_t;

  drive_set_t       expected_drives[$];
  drive_set_t       got;
  drive_set_t       want;
  logic [LVL_W-1:0] max_level = MAX_LEVEL_RST;
  logic [CFG_IDX_W-1:0] reg_idx;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  function automatic longint unsigned to_unit(input logic signed [SAT_W-1:0] x);
    if (x < 0) return 0;
    if (longint'(x) > longint'(ONE)) return ONE;
    return longint'(x);
  endfunction

  // cie lightness to luminance, 1.0 = 65536
  function automatic longint unsigned luminance_of(input longint unsigned v);
    longint unsigned a;
    longint unsigned t;
    if (v * 25 <= 2 * ONE) return (v * 1000 * 65536) / (9023 * ONE);
    a = v * 100 + 16 * ONE;
    t = (a * 65536) / (116 * ONE);
    return (t * t * t) >> 32;
  endfunction

  // common-anode inversion, scaled by max_level and truncated
  function automatic logic [LVL_W-1:0] drive_of(input longint unsigned x,
                                                input logic [LVL_W-1:0] lvl);
    longint unsigned prod;
    prod = ((64'd65536 - x) * 64'(lvl)) >> 16;
    return prod[LVL_W-1:0];
  endfunction

  function automatic drive_set_t predict_drive(input logic signed [HUE_W-1:0] hue,
                                               input logic signed [SAT_W-1:0] sat,
                                               input logic signed [SAT_W-1:0] bri,
                                               input logic [LVL_W-1:0] lvl);
    longint          hs;
    longint unsigned s, y, h, rem, sf, sg, p, q, t, r, g, b;
    sector_e         sec;
    drive_set_t      d;
    hs = longint'(hue);
    s  = to_unit(sat);
    y  = luminance_of(to_unit(bri));
    // negative hue clamps to 0, 360 degrees and above wrap to 0
    if (hs < 0 || hs >= HUE_FULL) hs = 0;
    if (s == 0) begin
      r = y;
      g = y;
      b = y;
    end else begin
      h   = longint'(hs);
      sec = sector_e'(h / HUE_SECTOR);
      rem = h % HUE_SECTOR;
      sf  = (s * rem) / HUE_SECTOR;
      sg  = (s * (HUE_SECTOR - rem)) / HUE_SECTOR;
      p   = (y * (ONE - s)) >> FRAC;
      q   = (y * (ONE - sf)) >> FRAC;
      t   = (y * (ONE - sg)) >> FRAC;
      case (sec)
        SEC_RED_YEL: begin r = y; g = t; b = p; end
        SEC_YEL_GRN: begin r = q; g = y; b = p; end
        SEC_GRN_CYN: begin r = p; g = y; b = t; end
        SEC_CYN_BLU: begin r = p; g = q; b = y; end
        SEC_BLU_MAG: begin r = t; g = p; b = y; end
        default: begin r = y; g = p; b = q; end
      endcase
    end
    d.red   = drive_of(r, lvl);
    d.green = drive_of(g, lvl);
    d.blue  = drive_of(b, lvl);
    return d;
  endfunction

  task automatic check_field(input string name, input logic [LVL_W-1:0] exp_v,
                             input logic [LVL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      max_level = MAX_LEVEL_RST;
    end else begin
      if (hsv_i.valid && hsv_i.ready) begin
        expected_drives.push_back(predict_drive(hsv_i.hue_deg16, hsv_i.saturation,
                                                hsv_i.brightness, max_level));
      end
      if (rgb_i.valid && rgb_i.ready) begin
        got = '{rgb_i.red, rgb_i.green, rgb_i.blue};
        if (expected_drives.size() == 0) begin
          $display("%0t: drive result with no request pending, expected none, actual %0d %0d %0d",
                   $time, got.red, got.green, got.blue);
          fail_cnt_o++;
        end else begin
          want = expected_drives.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
        end
      end
      reg_idx = paddr[CFG_ADDR_W-1:2];
      if (psel && penable && pready && reg_idx == REG_MAX_LEVEL) begin
        if (pwrite) begin
          max_level = pwdata[LVL_W-1:0];
        end else if (prdata !== CFG_DATA_W'(max_level)) begin
          $display("%0t: max_level read mismatch, expected %0d, actual %0d",
                   $time, max_level, prdata);
          fail_cnt_o++;
        end
      end
    end
    pending_o = expected_drives.size();
  end

endmodule

>>> bench/tb_hsv_to_led_pwm.sv
// top of the hsv to led drive bench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module tb_hsv_to_led_pwm;
  import hsv_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_MAX_LEVEL + 1'b1;
  localparam int PHASES = 7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_cnt;
  int                    pending;
  int                    burst_left;

  logic signed [HUE_W-1:0] hue_edges [6] = '{0, 959, 960, 5759, 5760, -1};
  logic signed [SAT_W-1:0] unit_edges [6] = '{0, 1, 327, 328, 4096, 4097};
  logic [LVL_W-1:0]        phase_levels [PHASES];

  hsv_in_if  hsv();
  hsv_out_if rgb();

  hsv_to_led_pwm dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hsv_i   (hsv),
    .rgb_o   (rgb),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hsv_drive_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hsv_i      (hsv),
    .rgb_i      (rgb),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("tb_hsv_to_led_pwm: FAIL");
    $finish;
  end

  task automatic cfg_access(input logic wr, input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_color(input logic signed [HUE_W-1:0] hue,
                            input logic signed [SAT_W-1:0] sat,
                            input logic signed [SAT_W-1:0] bri);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        hsv.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    hsv.valid      <= 1'b1;
    hsv.hue_deg16  <= hue;
    hsv.saturation <= sat;
    hsv.brightness <= bri;
    do @(posedge clk_i); while (!hsv.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_random();
    logic [31:0]             raw;
    logic signed [HUE_W-1:0] h;
    logic signed [SAT_W-1:0] s;
    logic signed [SAT_W-1:0] v;
    int                      pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      raw = $urandom;
      h   = raw[HUE_W-1:0];
      raw = $urandom;
      s   = raw[SAT_W-1:0];
      v   = raw[2*SAT_W-1:SAT_W];
    end else if (pick < 9) begin
      h = HUE_W'($urandom_range(0, HUE_FULL));
      s = ($urandom_range(0, 9) == 0) ? '0 : SAT_W'($urandom_range(0, 4096));
      v = SAT_W'($urandom_range(0, 4096));
    end else begin
      h = hue_edges[$urandom_range(0, 5)];
      s = unit_edges[$urandom_range(0, 5)];
      v = unit_edges[$urandom_range(0, 5)];
    end
    send_color(h, s, v);
  endtask

  // stop offering requests until every result is back
  task automatic drain();
    hsv.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: stalls in segments of varying character
  initial begin
    rx_mode_e mode;
    int       seg;
    rgb.ready = 1'b0;
    @(posedge rst_ni);
    // long hold at the start so the directed requests back up into the input
    repeat (100) @(negedge clk_i);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(20, 150);
      case (mode)
        RX_OPEN: begin
          rgb.ready <= 1'b1;
          repeat (seg) @(negedge clk_i);
        end
        RX_COIN: begin
          repeat (seg) begin
            rgb.ready <= 1'($urandom_range(0, 1));
            @(negedge clk_i);
          end
        end
        RX_SPARSE: begin
          repeat (seg) begin
            rgb.ready <= ($urandom_range(0, 7) == 0);
            @(negedge clk_i);
          end
        end
        default: begin
          rgb.ready <= 1'b0;
          repeat ($urandom_range(30, 80)) @(negedge clk_i);
        end
      endcase
    end
  end

  initial begin
    logic [31:0] raw;
    hsv.valid      = 1'b0;
    hsv.hue_deg16  = '0;
    hsv.saturation = '0;
    hsv.brightness = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    burst_left     = 0;
    rst_ni         = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    cfg_access(1'b0, REG_MAX_LEVEL, '0);
    // upper data bits set, only the low 16 land
    cfg_access(1'b1, REG_MAX_LEVEL, 32'hFFFF_FFFF);
    cfg_access(1'b1, REG_SPARE, $urandom);
    cfg_access(1'b0, REG_MAX_LEVEL, '0);

    // clamping of out-of-range fields
    send_color(16'sh8000, 14'sd8191, 14'sd8191);
    send_color(16'sh7FFF, -14'sd8192, -14'sd8192);
    send_color(-16'sd1, 14'sd4097, 14'sd4097);
    // full circle wraps to red
    send_color(16'sd5760, 14'sd4096, 14'sd4096);
    send_color(16'sd5759, 14'sd4096, 14'sd4096);
    // grey
    send_color(16'sd1234, 14'sd0, 14'sd4096);
    send_color(16'sd0, 14'sd0, 14'sd2000);
    // each sector, at its start or its middle
    send_color(16'sd0, 14'sd3000, 14'sd3500);
    send_color(16'sd480, 14'sd3000, 14'sd3500);
    send_color(16'sd1440, 14'sd3000, 14'sd3500);
    send_color(16'sd1920, 14'sd3000, 14'sd3500);
    send_color(16'sd2400, 14'sd3000, 14'sd3500);
    send_color(16'sd3360, 14'sd3000, 14'sd3500);
    send_color(16'sd3840, 14'sd3000, 14'sd3500);
    send_color(16'sd5280, 14'sd3000, 14'sd3500);
    send_color(16'sd959, 14'sd4096, 14'sd4096);
    // linear and cubic lightness segments around the 8 percent knee
    send_color(16'sd600, 14'sd4096, 14'sd0);
    send_color(16'sd600, 14'sd4096, 14'sd1);
    send_color(16'sd600, 14'sd4096, 14'sd327);
    send_color(16'sd600, 14'sd4096, 14'sd328);
    send_color(16'sd2000, 14'sd1, 14'sd4096);
    send_color(16'sd4800, 14'sd4095, 14'sd4095);
    drain();

    phase_levels = '{16'd1, 16'd0, 16'h8000, LVL_W'($urandom_range(2, 65534)),
                     MAX_LEVEL_RST, LVL_W'($urandom), 16'hFFFF};
    for (int k = 0; k < PHASES; k++) begin
      raw = $urandom;
      cfg_access(1'b1, REG_MAX_LEVEL, {raw[31:16], phase_levels[k]});
      cfg_access(1'b0, REG_MAX_LEVEL, '0);
      repeat (260) send_random();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_hsv_to_led_pwm: PASS");
    end else begin
      $display("tb_hsv_to_led_pwm: FAIL");
    end
    $finish;
  end

endmodule
